@@ rtl/core/txcon_pkg.sv @@
// Shared types and constants for the text console character engine
`timescale 1ns / 1ps

package txcon_pkg;

   // character codes handled by the put path
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   // attribute used for the cells after reset and for text_color after reset
   localparam logic [7:0] COLOR_RESET  = 8'h0F;

   // result word field widths
   localparam int CELL_W = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int POS_OUT_W = 11;
   localparam int RSP_W = CELL_W + ROW_OUT_W + COL_OUT_W + POS_OUT_W + 1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;         // input word accepted this cycle
      logic exec;         // apply the held item to cursor and store
      logic sweep_run;    // run the store sweep
      logic sweep_clear;  // sweep fills every cell with the reset cell
      logic sweep_start;  // restart the sweep counter
      logic load_out;     // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scroll_need;  // held put moves past the last row
      logic sweep_done;   // last sweep write happens this cycle
      logic out_free;     // output register can take a word
   } status_type;

endpackage

@@ rtl/core/text_console_char_engine.sv @@
// A put or read word, once accepted, passes the ST_EXEC and ST_OUT states and is then held in the output
// register on rsp; ST_OUT waits while the output register is full. A put that scrolls also runs a sweep of
// the store, one cell a cycle through the single write port of the cell store. No new word is taken until
// the result is loaded into the output register. Reset is synchronous; after it a clearing pass
// fills the store with white-on-black spaces while req_tready stays low.
// Top level of the text console character engine
`timescale 1ns / 1ps

module text_console_char_engine
   import txcon_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic        clock,
   input  logic        reset,
   // request: tdata = char_code[7:0], read_addr[18:8], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // request: tuser = kind
   input  logic        req_tuser,
   // response: tdata = cell_value[15:0], cursor_row[20:16], cursor_col[27:21],
   // cursor_pos[38:28], scrolled[39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // text colour register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   cmd_type    cmd;
   status_type status;
   state_type  state;

   assign csr_ready = 1'b1;

   // controller
   txcon_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   // datapath
   txcon_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_kind   (req_tuser),
      .req_char   (req_tdata[7:0]),
      .req_addr   (req_tdata[18:8]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   // no input word is taken during the clearing pass
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state == ST_CLEAR) |-> !req_tready)
      else $error("input taken during clearing pass");

   // a put never runs while the sweep owns the store
   a_exec_not_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_run |-> !cmd.exec)
      else $error("put executed during sweep");

   // a scrolled result has the cursor on the last row and no cell value
   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39]) |->
         (rsp_tdata[20:16] == ROW_OUT_W'(ROWS - 1)) && (rsp_tdata[15:0] == '0))
      else $error("scroll result not on last row");

   // reported column stays inside the line
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[27:21]) < COLUMNS))
      else $error("cursor column out of range");
`endif

endmodule

@@ rtl/core/txcon_ctrl.sv @@
// Controller state machine for the text console character engine
`timescale 1ns / 1ps

module txcon_ctrl
   import txcon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd,
   output state_type  state
);

   state_type state_ff;
   state_type state_in;

   // state register, reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_run   = 1'b1;
            cmd.sweep_clear = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.scroll_need) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SCROLL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SCROLL: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign state = state_ff;

endmodule

@@ rtl/core/txcon_dp.sv @@
// Datapath: cell store, cursor, store sweep and output register
`timescale 1ns / 1ps

module txcon_dp
   import txcon_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_kind,
   input  logic [7:0]           req_char,
   input  logic [10:0]          req_addr,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [RSP_W-1:0]     rsp_tdata
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int LAST_BASE  = CELL_COUNT - COLUMNS;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int IDX_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);

   // configuration
   logic [7:0]          text_color_ff;

   // cursor: row, column and row start index
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [CELL_AW-1:0]  base_ff, base_in;

   // held item
   logic                kind_ff;
   logic [7:0]          char_ff;
   logic                addr_ok_ff;

   // cell store
   logic [CELL_W-1:0]   cells [CELL_COUNT];
   logic [CELL_W-1:0]   rdata_ff;
   logic                mem_we;
   logic [CELL_AW-1:0]  mem_wa;
   logic [CELL_W-1:0]   mem_wd;
   logic [CELL_AW-1:0]  mem_ra;

   // sweep pipeline: issue stage counter, write stage
   logic [IDX_W-1:0]    sweep_idx_ff;
   logic                sweep_issue;
   logic                sweep_wv_ff;
   logic [CELL_AW-1:0]  sweep_wa_ff;
   logic                sweep_fill_ff;
   logic                sweep_clr_ff;
   logic [CELL_AW-1:0]  sweep_ra;

   // held result
   logic [CELL_W-1:0]   cell_hold_ff;
   logic                scrolled_hold_ff;

   // output register
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;

   // put decode
   logic                is_nl, is_bs, last_col, last_row, advance, put_write;
   logic [COL_W-1:0]    col_wr;

   assign is_nl     = (char_ff == CH_NEWLINE);
   assign is_bs     = (char_ff == CH_BACKSPACE);
   assign last_col  = (col_ff == COL_W'(COLUMNS - 1));
   assign last_row  = (row_ff == ROW_W'(ROWS - 1));
   assign advance   = !kind_ff && (is_nl || (!is_bs && last_col));
   assign put_write = !kind_ff && !is_nl && (!is_bs || (col_ff != '0));
   assign col_wr    = is_bs ? col_ff - COL_W'(1) : col_ff;

   // text colour register
   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_RESET;
      end else if (csr_valid) begin
         text_color_ff <= csr_data;
      end
   end

   // capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff    <= req_kind;
         char_ff    <= req_char;
         addr_ok_ff <= (32'(req_addr) < CELL_COUNT);
      end
   end

   // cursor update for a put
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      if (cmd.exec && !kind_ff) begin
         if (advance) begin
            col_in = '0;
            if (!last_row) begin
               row_in  = row_ff + ROW_W'(1);
               base_in = base_ff + CELL_AW'(COLUMNS);
            end
         end else if (is_bs) begin
            // backspace at column zero leaves the cursor alone
            if (col_ff != '0) begin
               col_in = col_wr;
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         base_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         base_ff <= base_in;
      end
   end

   // sweep issue stage: reads the cell one row below, marks fill cells
   assign sweep_issue = cmd.sweep_run && (sweep_idx_ff < IDX_W'(CELL_COUNT));
   assign sweep_ra    = (sweep_idx_ff < IDX_W'(LAST_BASE)) ?
                        CELL_AW'(sweep_idx_ff + IDX_W'(COLUMNS)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_idx_ff <= '0;
         sweep_wv_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sweep_idx_ff <= '0;
         end else if (sweep_issue) begin
            sweep_idx_ff <= sweep_idx_ff + IDX_W'(1);
         end
         sweep_wv_ff <= sweep_issue;
      end
   end

   always_ff @(posedge clock) begin
      sweep_wa_ff   <= CELL_AW'(sweep_idx_ff);
      sweep_fill_ff <= cmd.sweep_clear || (sweep_idx_ff >= IDX_W'(LAST_BASE));
      sweep_clr_ff  <= cmd.sweep_clear;
   end

   // store write and read port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = sweep_wa_ff;
      mem_wd = rdata_ff;
      if (sweep_wv_ff) begin
         mem_we = 1'b1;
         if (sweep_fill_ff) begin
            mem_wd = {(sweep_clr_ff ? COLOR_RESET : text_color_ff), CH_SPACE};
         end
      end else if (cmd.exec && put_write) begin
         mem_we = 1'b1;
         mem_wa = CELL_AW'(base_ff + CELL_AW'(col_wr));
         mem_wd = {text_color_ff, (is_bs ? CH_SPACE : char_ff)};
      end
      mem_ra = cmd.sweep_run ? sweep_ra : CELL_AW'(req_addr);
   end

   // cell store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_wa] <= mem_wd;
      end
      rdata_ff <= cells[mem_ra];
   end

   // held result of the item
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cell_hold_ff     <= (kind_ff && addr_ok_ff) ? rdata_ff : '0;
         scrolled_hold_ff <= advance && last_row;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {scrolled_hold_ff,
                         POS_OUT_W'(CELL_AW'(base_ff + CELL_AW'(col_ff))),
                         COL_OUT_W'(col_ff),
                         ROW_OUT_W'(row_ff),
                         cell_hold_ff};
      end
   end

   // status back to the controller
   assign status.scroll_need = advance && last_row;
   assign status.sweep_done  = sweep_wv_ff && (sweep_wa_ff == CELL_AW'(CELL_COUNT - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ dv/tb_text_console_char_engine.sv @@
// Self-checking testbench for the text console character engine: predicts every result word
`timescale 1ns / 1ps

module tb_text_console_char_engine;
   import txcon_pkg::*;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int PHASE_WORDS  = 310;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int IDLE_PERCENT = 31;

   // request kind carried on tuser
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] code;
      logic [10:0] addr;
   } console_word_type;

   // laid out from the top bit down, so it matches the result word directly
   typedef struct packed {
      logic        scrolled;
      logic [10:0] pos;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [15:0] cell_value;
   } cursor_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = '0;

   // words waiting to be typed and reports waiting to come back
   console_word_type  typing_q[$];
   cursor_report_type awaited_reports[$];

   // predicted console state
   logic [15:0] cell_store [0:CELL_COUNT-1];
   int          pen_row;
   int          pen_col;
   logic [7:0]  pen_color;

   int  taken_count = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   logic calm;

   assign calm = (taken_count >= 600) && (taken_count < 900);

   always #5 clock = ~clock;

   text_console_char_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // apply one word to the predicted console and return the report it should give
   function automatic cursor_report_type advance_console(console_word_type w);
      cursor_report_type r;
      r = '0;
      if (w.kind == KIND_READ) begin
         if (w.addr < CELL_COUNT) r.cell_value = cell_store[w.addr];
      end else begin
         if (w.code == CH_NEWLINE) begin
            pen_col = 0;
            pen_row++;
         end else if (w.code == CH_BACKSPACE) begin
            if (pen_col != 0) begin
               pen_col--;
               cell_store[pen_row * COLUMNS + pen_col] = {pen_color, CH_SPACE};
            end
         end else begin
            cell_store[pen_row * COLUMNS + pen_col] = {pen_color, w.code};
            pen_col++;
            if (pen_col >= COLUMNS) begin
               pen_col = 0;
               pen_row++;
            end
         end
         // past the last row: shift everything up a row, blank the bottom one
         if (pen_row >= ROWS) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
               cell_store[i] = cell_store[i + COLUMNS];
            for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
               cell_store[i] = {pen_color, CH_SPACE};
            pen_row = ROWS - 1;
            r.scrolled = 1'b1;
         end
      end
      r.row = pen_row[4:0];
      r.col = pen_col[6:0];
      r.pos = 11'(pen_row * COLUMNS + pen_col);
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // driver: feeds request words and tracks the predicted state on each accepted word
   always @(posedge clock) begin
      console_word_type w;
      if (reset) begin
         for (int i = 0; i < CELL_COUNT; i++) cell_store[i] = {COLOR_RESET, CH_SPACE};
         pen_row = 0;
         pen_col = 0;
         pen_color = COLOR_RESET;
         req_tvalid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) pen_color = csr_data;
         if (req_tvalid && req_tready) begin
            w.kind = req_tuser;
            w.code = req_tdata[7:0];
            w.addr = req_tdata[18:8];
            awaited_reports.push_back(advance_console(w));
            taken_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (typing_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               w = typing_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= w.kind;
               req_tdata  <= {5'b0, w.addr, w.code};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure and field-by-field check of each result word
   always @(posedge clock) begin
      cursor_report_type want;
      cursor_report_type got;
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = awaited_reports.pop_front();
            check_field("cell_value", want.cell_value, got.cell_value);
            check_field("cursor_row", want.row, got.row);
            check_field("cursor_col", want.col, got.col);
            check_field("cursor_pos", want.pos, got.pos);
            check_field("scrolled", want.scrolled, got.scrolled);
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_word(logic kind, logic [7:0] code, logic [10:0] addr);
      console_word_type w;
      w.kind = kind;
      w.code = code;
      w.addr = addr;
      typing_q.push_back(w);
   endtask

   // random text: mostly printed bytes, some newlines and backspaces, reads mixed in
   task automatic queue_random_text(int n);
      int pick;
      int where;
      logic [10:0] addr;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            where = $urandom_range(0, 9);
            if (where == 0) addr = 11'($urandom_range(CELL_COUNT, 2047));
            else if (where < 4) addr = 11'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
            else addr = 11'($urandom_range(0, CELL_COUNT - 1));
            queue_word(KIND_READ, 8'($urandom_range(0, 255)), addr);
         end else if (pick < 32) begin
            queue_word(KIND_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
         end else if (pick < 40) begin
            queue_word(KIND_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
         end else begin
            queue_word(KIND_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
         end
      end
   endtask

   // hold off until every word is in and every report is back
   task automatic wait_drained();
      while (typing_q.size() != 0 || req_tvalid || awaited_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_text_color(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: backspace at column zero, reads at the store edges and beyond,
      // extreme bytes, backspace mid-line, newline
      queue_word(KIND_PUT, CH_BACKSPACE, 11'd0);
      queue_word(KIND_READ, 8'h00, 11'd0);
      queue_word(KIND_READ, 8'hFF, 11'(CELL_COUNT - 1));
      queue_word(KIND_READ, 8'h00, 11'(CELL_COUNT));
      queue_word(KIND_READ, 8'h00, 11'h7FF);
      queue_word(KIND_PUT, 8'h00, 11'h7FF);
      queue_word(KIND_PUT, 8'hFF, 11'd0);
      queue_word(KIND_PUT, CH_SPACE, 11'd0);
      queue_word(KIND_PUT, 8'h41, 11'd0);
      queue_word(KIND_PUT, CH_BACKSPACE, 11'd0);
      queue_word(KIND_READ, 8'h00, 11'd3);
      queue_word(KIND_READ, 8'h00, 11'd0);
      queue_word(KIND_READ, 8'h00, 11'd1);
      queue_word(KIND_PUT, CH_NEWLINE, 11'd0);
      queue_word(KIND_PUT, 8'h7F, 11'd0);
      queue_word(KIND_PUT, CH_BACKSPACE, 11'd0);
      queue_word(KIND_PUT, CH_BACKSPACE, 11'd0);
      queue_word(KIND_READ, 8'h00, 11'(COLUMNS));
      wait_drained();

      // random phases, each preceded by a text colour write
      write_text_color(8'hFF);
      queue_random_text(PHASE_WORDS);
      wait_drained();
      write_text_color(8'h00);
      queue_random_text(PHASE_WORDS);
      wait_drained();
      write_text_color(8'($urandom_range(0, 255)));
      queue_random_text(PHASE_WORDS);
      wait_drained();
      write_text_color(8'($urandom_range(0, 255)));
      queue_random_text(PHASE_WORDS);
      wait_drained();
      write_text_color(COLOR_RESET);
      queue_random_text(PHASE_WORDS);
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
